// File: design/rfrs_pkg.sv
// Shared types and constants of the raw frame region statistics block.
`default_nettype none
package rfrs_pkg;

    localparam int SMP_W     = 16;
    localparam int SUM_W     = 36;
    localparam int CNT_W     = 21;
    localparam int MEAN_W    = 24;
    localparam int RGN_W     = 3;
    localparam int NGRP      = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 11;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_AREA_LEFT    = 3'd2,
        CFG_AREA_TOP     = 3'd3,
        CFG_AREA_WIDTH   = 3'd4,
        CFG_AREA_HEIGHT  = 3'd5
    } t_cfg_idx;

    // result region codes
    localparam logic [RGN_W-1:0] RGN_ACTIVE   = 3'd0;
    localparam logic [RGN_W-1:0] RGN_RIGHT    = 3'd1;
    localparam logic [RGN_W-1:0] RGN_BOTTOM   = 3'd2;
    localparam logic [RGN_W-1:0] RGN_INACTIVE = 3'd3;
    localparam logic [RGN_W-1:0] RGN_LAST     = 3'd7;

    // accumulator group slots
    localparam int GRP_ACTIVE = 0;
    localparam int GRP_RIGHT  = 1;
    localparam int GRP_BOTTOM = 2;
    localparam int GRP_SITE0  = 3;

    typedef struct packed {
        logic [10:0] frame_width;
        logic [10:0] frame_height;
        logic [9:0]  area_left;
        logic [9:0]  area_top;
        logic [10:0] area_width;
        logic [10:0] area_height;
    } t_cfg;

    typedef struct packed {
        logic [SMP_W-1:0] mn;
        logic [SMP_W-1:0] mx;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
    } t_group;

    typedef t_group [NGRP-1:0] t_snap;

    // handshake between the frame queue and its consumer
    typedef struct packed {
        logic valid;
        logic pop;
    } t_snap_ctl;

    typedef struct packed {
        logic [RGN_W-1:0]  region;
        logic [SMP_W-1:0]  mn;
        logic [SMP_W-1:0]  mx;
        logic [SUM_W-1:0]  sum;
        logic [CNT_W-1:0]  cnt;
        logic [MEAN_W-1:0] mean;
        logic              last;
    } t_result;

endpackage
`default_nettype wire

// File: design/raw_frame_region_statistics.sv
// Top level of the raw frame region statistics block.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  sample   | i_push / o_full           | i_sample, i_frame_start
//  result   | o_empty / i_pop           | o_region, o_minimum, o_maximum, o_total,
//           |                           | o_sample_count, o_mean_q8, o_last
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Samples are taken one per cycle while o_full is low; classification and accumulation
// finish in that cycle. After a frame's last sample the group totals go into a two-frame
// queue; the result sequencer then steps each region through a 44-step serial divider for
// the mean, eight results per frame. o_full rises while two frames wait.
// Synchronous active-low reset clears positions, accumulators, queues; presets registers.
`default_nettype none
module raw_frame_region_statistics
    import rfrs_pkg::*;
#(
    parameter int MAX_DIM     = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    output logic                      o_full,
    input  wire logic [SMP_W-1:0]     i_sample,
    input  wire logic                 i_frame_start,
    output logic                      o_empty,
    input  wire logic                 i_pop,
    output logic [RGN_W-1:0]          o_region,
    output logic [SMP_W-1:0]          o_minimum,
    output logic [SMP_W-1:0]          o_maximum,
    output logic [SUM_W-1:0]          o_total,
    output logic [CNT_W-1:0]          o_sample_count,
    output logic [MEAN_W-1:0]         o_mean_q8,
    output logic                      o_last,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    logic      snap_push;
    t_snap     snap_in, snap_out;
    t_snap_ctl q_ctl, b_ctl;
    t_result   res;

    assign o_cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= 11'd1024;
            r_cfg.frame_height <= 11'd1024;
            r_cfg.area_left    <= '0;
            r_cfg.area_top     <= '0;
            r_cfg.area_width   <= 11'd1024;
            r_cfg.area_height  <= 11'd1024;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg_data;
                CFG_AREA_LEFT:    r_cfg.area_left    <= i_cfg_data[9:0];
                CFG_AREA_TOP:     r_cfg.area_top     <= i_cfg_data[9:0];
                CFG_AREA_WIDTH:   r_cfg.area_width   <= i_cfg_data;
                CFG_AREA_HEIGHT:  r_cfg.area_height  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rfrs_front #(
        .MAX_DIM     (MAX_DIM),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_accept      (i_push && !o_full),
        .i_sample      (i_sample),
        .i_frame_start (i_frame_start),
        .o_snap_push   (snap_push),
        .o_snap        (snap_in)
    );

    rfrs_snap_q u_snap_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (snap_push),
        .i_snap   (snap_in),
        .o_full   (o_full),
        .o_snap   (snap_out),
        .i_ctl_in (b_ctl),
        .o_ctl    (q_ctl)
    );

    rfrs_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_snap  (snap_out),
        .i_ctl   (q_ctl),
        .o_ctl   (b_ctl),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_res   (res)
    );

    assign o_region       = res.region;
    assign o_minimum      = res.mn;
    assign o_maximum      = res.mx;
    assign o_total        = res.sum;
    assign o_sample_count = res.cnt;
    assign o_mean_q8      = res.mean;
    assign o_last         = res.last;

endmodule
`default_nettype wire

// File: design/rfrs_front.sv
// Raster position tracking, sample classification and group accumulation.
`default_nettype none
module rfrs_front
    import rfrs_pkg::*;
#(
    parameter int MAX_DIM     = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg             i_cfg,
    input  wire logic             i_accept,
    input  wire logic [SMP_W-1:0] i_sample,
    input  wire logic             i_frame_start,
    output logic                  o_snap_push,
    output t_snap                 o_snap
);

    localparam int POS_W = $clog2(MAX_DIM);
    localparam int CW    = ((POS_W > 11) ? POS_W : 11) + 2;
    localparam logic [SMP_W-1:0] SMASK = SMP_W'((17'd1 << SAMPLE_BITS) - 17'd1);
    localparam t_group CLR = '{mn: SMASK, mx: '0, sum: '0, cnt: '0};

    logic [POS_W-1:0] r_row, r_col;
    t_snap            r_acc;
    t_snap            n_acc;

    logic [CW-1:0]    fw, fh, w, h, rx, cx, top, left, bot_edge, rgt_edge;
    logic [POS_W-1:0] cur_row, cur_col;
    logic [SMP_W-1:0] v;
    logic             rows_act, cols_act, col_end, row_end, frame_end;
    logic [NGRP-1:0]  hit;
    logic [1:0]       site;

    // clamp frame size and locate the sample
    always_comb begin
        fw       = CW'(i_cfg.frame_width);
        fh       = CW'(i_cfg.frame_height);
        w        = (fw == '0) ? CW'(1) : ((fw > CW'(MAX_DIM)) ? CW'(MAX_DIM) : fw);
        h        = (fh == '0) ? CW'(1) : ((fh > CW'(MAX_DIM)) ? CW'(MAX_DIM) : fh);
        cur_row  = i_frame_start ? '0 : r_row;
        cur_col  = i_frame_start ? '0 : r_col;
        rx       = CW'(cur_row);
        cx       = CW'(cur_col);
        top      = CW'(i_cfg.area_top);
        left     = CW'(i_cfg.area_left);
        bot_edge = top + CW'(i_cfg.area_height);
        rgt_edge = left + CW'(i_cfg.area_width);
        rows_act = (rx >= top) && (rx < bot_edge);
        cols_act = (cx >= left) && (cx < rgt_edge);
        col_end  = (cx + CW'(1)) >= w;
        row_end  = (rx + CW'(1)) >= h;
        frame_end = col_end && row_end;
        v        = i_sample & SMASK;
        site     = {rx[0] ^ top[0], cx[0] ^ left[0]};
    end

    // classify into groups
    always_comb begin
        hit = '0;
        if (rows_act && cols_act) begin
            hit[GRP_ACTIVE] = 1'b1;
            hit[GRP_SITE0 + int'(site)] = 1'b1;
        end else if (rows_act && (cx >= rgt_edge)) begin
            hit[GRP_RIGHT] = 1'b1;
        end else if (rx >= bot_edge) begin
            hit[GRP_BOTTOM] = 1'b1;
        end
    end

    // update each group with the sample
    always_comb begin
        t_group b;
        for (int g = 0; g < NGRP; g++) begin
            b = i_frame_start ? CLR : r_acc[g];
            if (hit[g]) begin
                b.mn  = (v < b.mn) ? v : b.mn;
                b.mx  = (v > b.mx) ? v : b.mx;
                b.sum = b.sum + SUM_W'(v);
                b.cnt = b.cnt + CNT_W'(1);
            end
            n_acc[g] = b;
        end
    end

    assign o_snap_push = i_accept && frame_end;
    assign o_snap      = n_acc;

    // advance position, restart accumulators after the last sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_acc <= {NGRP{CLR}};
        end else if (i_accept) begin
            r_col <= col_end ? '0 : cur_col + POS_W'(1);
            if (col_end) begin
                r_row <= row_end ? '0 : cur_row + POS_W'(1);
            end else begin
                r_row <= cur_row;
            end
            r_acc <= frame_end ? {NGRP{CLR}} : n_acc;
        end
    end

endmodule
`default_nettype wire

// File: design/rfrs_snap_q.sv
// Two-entry queue of finished frame group totals.
`default_nettype none
module rfrs_snap_q
    import rfrs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_snap i_snap,
    output logic       o_full,
    output t_snap      o_snap,
    input  wire t_snap_ctl i_ctl_in,
    output t_snap_ctl  o_ctl
);

    t_snap      r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       pop;

    assign o_full      = r_cnt == 2'd2;
    assign o_ctl.valid = r_cnt != 2'd0;
    assign o_ctl.pop   = 1'b0;
    assign pop         = i_ctl_in.pop && o_ctl.valid;
    assign o_snap      = r_mem[r_rd];

    // store a pushed snapshot
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr] <= i_snap;
        end
    end

    // track pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wr <= ~r_wr;
            if (pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'((i_push && !o_full) ? 1 : 0) - 2'(pop ? 1 : 0);
        end
    end

endmodule
`default_nettype wire

// File: design/rfrs_back.sv
// Result sequencer: per-region selection, serial mean divider, output queue.
`default_nettype none
module rfrs_back
    import rfrs_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_snap     i_snap,
    input  wire t_snap_ctl i_ctl,
    output t_snap_ctl      o_ctl,
    output logic           o_empty,
    input  wire logic      i_pop,
    output t_result        o_res
);

    localparam logic [SMP_W-1:0] SMASK = SMP_W'((17'd1 << SAMPLE_BITS) - 17'd1);
    localparam int DVD_W  = SUM_W + 8;
    localparam int STEP_W = $clog2(DVD_W);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_PUSH} t_state;

    t_state            r_state;
    logic [RGN_W-1:0]  r_rgn;
    logic [SMP_W-1:0]  r_mn, r_mx;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_cnt;
    logic [DVD_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_rem;
    logic [MEAN_W-1:0] r_q;
    logic [STEP_W-1:0] r_step;

    t_group            sel;
    logic [CNT_W:0]    rem2;
    logic              ge;

    t_result           r_oq [2];
    logic              r_owr, r_ord;
    logic [1:0]        r_ocnt;
    logic              ofull, opush, opop;
    t_result           res;

    // pick the statistics of the current region
    always_comb begin
        t_group a, b;
        a = i_snap[GRP_RIGHT];
        b = i_snap[GRP_BOTTOM];
        unique case (r_rgn)
            RGN_ACTIVE: sel = i_snap[GRP_ACTIVE];
            RGN_RIGHT:  sel = a;
            RGN_BOTTOM: sel = b;
            RGN_INACTIVE: begin
                sel.sum = a.sum + b.sum;
                sel.cnt = a.cnt + b.cnt;
                sel.mn  = SMASK;
                sel.mx  = '0;
                if (a.cnt != '0) begin
                    sel.mn = a.mn;
                    sel.mx = a.mx;
                end
                if (b.cnt != '0) begin
                    sel.mn = (b.mn < sel.mn) ? b.mn : sel.mn;
                    sel.mx = (b.mx > sel.mx) ? b.mx : sel.mx;
                end
            end
            default: sel = i_snap[GRP_SITE0 + int'(r_rgn[1:0])];
        endcase
    end

    // one restoring division step
    assign rem2 = {r_rem, r_dvd[DVD_W-1]};
    assign ge   = rem2 >= {1'b0, r_cnt};

    assign o_ctl.valid = 1'b0;
    assign o_ctl.pop   = (r_state == S_PUSH) && !ofull && (r_rgn == RGN_LAST);

    assign res.region = r_rgn;
    assign res.mn     = r_mn;
    assign res.mx     = r_mx;
    assign res.sum    = r_sum;
    assign res.cnt    = r_cnt;
    assign res.mean   = (r_cnt == '0) ? '0 : r_q;
    assign res.last   = r_rgn == RGN_LAST;

    // sequence regions through the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rgn   <= RGN_ACTIVE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_ctl.valid) begin
                        r_mn    <= (sel.cnt == '0) ? '0 : sel.mn;
                        r_mx    <= (sel.cnt == '0) ? '0 : sel.mx;
                        r_sum   <= sel.sum;
                        r_cnt   <= sel.cnt;
                        r_dvd   <= {sel.sum, 8'h00};
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= ge ? CNT_W'(rem2 - {1'b0, r_cnt}) : rem2[CNT_W-1:0];
                    r_q    <= {r_q[MEAN_W-2:0], ge};
                    r_dvd  <= {r_dvd[DVD_W-2:0], 1'b0};
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(DVD_W - 1)) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!ofull) begin
                        r_rgn   <= r_rgn + RGN_W'(1);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output queue
    assign ofull   = r_ocnt == 2'd2;
    assign opush   = (r_state == S_PUSH) && !ofull;
    assign o_empty = r_ocnt == 2'd0;
    assign opop    = i_pop && !o_empty;
    assign o_res   = r_oq[r_ord];

    always_ff @(posedge i_clk) begin
        if (opush) begin
            r_oq[r_owr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= 1'b0;
            r_ord  <= 1'b0;
            r_ocnt <= '0;
        end else begin
            if (opush) r_owr <= ~r_owr;
            if (opop) r_ord <= ~r_ord;
            r_ocnt <= r_ocnt + 2'(opush ? 1 : 0) - 2'(opop ? 1 : 0);
        end
    end

endmodule
`default_nettype wire

// File: design/rfrs_checker.sv
// Port-level checks of the raw frame region statistics block, bound to the top level.
`default_nettype none
module rfrs_checker
    import rfrs_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_empty,
    input wire logic              i_pop,
    input wire logic [RGN_W-1:0]  o_region,
    input wire logic [SMP_W-1:0]  o_minimum,
    input wire logic [SMP_W-1:0]  o_maximum,
    input wire logic [CNT_W-1:0]  o_sample_count,
    input wire logic [MEAN_W-1:0] o_mean_q8,
    input wire logic              o_last
);

    // nothing waits right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> o_empty) else $error("result after reset");

    // final result of a frame is the last parity site
    a_last_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_last |-> o_region == RGN_LAST) else $error("last flag on wrong region");

    // empty group reports zeros
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_sample_count == '0 |->
            o_minimum == '0 && o_maximum == '0 && o_mean_q8 == '0)
        else $error("empty group not zero");

    // nonempty group is ordered
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_sample_count != '0 |-> o_minimum <= o_maximum)
        else $error("minimum above maximum");

    // a waiting result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_region) && $stable(o_mean_q8))
        else $error("waiting result changed");

endmodule

bind raw_frame_region_statistics rfrs_checker u_rfrs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_empty        (o_empty),
    .i_pop          (i_pop),
    .o_region       (o_region),
    .o_minimum      (o_minimum),
    .o_maximum      (o_maximum),
    .o_sample_count (o_sample_count),
    .o_mean_q8      (o_mean_q8),
    .o_last         (o_last)
);
`default_nettype wire

// File: bench/raw_frame_region_statistics_test.sv
// Self-checking testbench for the raw frame region statistics block.
`timescale 1ns / 1ps

// Tracks frame position and group statistics, and holds the region results still due.
class frame_stats_board;
    rfrs_pkg::t_result due_q[$];
    int               errors;
    int               frames;
    int               checked;
    logic [10:0]      fw, fh, aw, ah;
    logic [9:0]       al, at;
    int unsigned      row, col;
    logic [15:0]      gmin[7];
    logic [15:0]      gmax[7];
    logic [35:0]      gsum[7];
    logic [20:0]      gcnt[7];

    function new();
        fw = 11'd1024; fh = 11'd1024; al = '0; at = '0; aw = 11'd1024; ah = 11'd1024;
        row = 0; col = 0; errors = 0; frames = 0; checked = 0;
        clear_groups();
    endfunction

    function void clear_groups();
        for (int g = 0; g < 7; g++) begin
            gmin[g] = 16'hFFFF; gmax[g] = '0; gsum[g] = '0; gcnt[g] = '0;
        end
    endfunction

    function void set_reg(rfrs_pkg::t_cfg_idx idx, logic [10:0] d);
        case (idx)
            rfrs_pkg::CFG_FRAME_WIDTH:  fw = d;
            rfrs_pkg::CFG_FRAME_HEIGHT: fh = d;
            rfrs_pkg::CFG_AREA_LEFT:    al = d[9:0];
            rfrs_pkg::CFG_AREA_TOP:     at = d[9:0];
            rfrs_pkg::CFG_AREA_WIDTH:   aw = d;
            rfrs_pkg::CFG_AREA_HEIGHT:  ah = d;
            default: ;
        endcase
    endfunction

    function void add(int g, logic [15:0] v);
        if (v < gmin[g]) gmin[g] = v;
        if (v > gmax[g]) gmax[g] = v;
        gsum[g] = gsum[g] + 36'(v);
        gcnt[g] = gcnt[g] + 21'd1;
    endfunction

    function rfrs_pkg::t_result make(logic [2:0] r, logic [15:0] mn, logic [15:0] mx,
                                     logic [35:0] sum, logic [20:0] cnt, logic last);
        rfrs_pkg::t_result res;
        logic [63:0] q;
        q = 0;
        if (cnt == 0) begin
            mn = 0; mx = 0;
        end else begin
            q = ({28'd0, sum} << 8) / {43'd0, cnt};
        end
        res.region = r; res.mn = mn; res.mx = mx; res.sum = sum; res.cnt = cnt;
        res.mean = q[23:0]; res.last = last;
        return res;
    endfunction

    // Append one expected result behind those already due.
    function void queue_due(rfrs_pkg::t_result r);
        due_q = {due_q, r};
    endfunction

    // Classify one sample, advance the raster position, queue results at frame end.
    function void note_sample(logic [15:0] v, logic fs);
        int unsigned w, h, redge, bedge;
        bit rows_on, cols_on;
        logic [15:0] mn, mx;
        if (fs) begin
            row = 0; col = 0; clear_groups();
        end
        w = (fw == 0) ? 1 : (fw > 1024) ? 1024 : fw;
        h = (fh == 0) ? 1 : (fh > 1024) ? 1024 : fh;
        redge = al + aw;
        bedge = at + ah;
        rows_on = row >= at && row < bedge;
        cols_on = col >= al && col < redge;
        if (rows_on && cols_on) begin
            add(rfrs_pkg::GRP_ACTIVE, v);
            add(rfrs_pkg::GRP_SITE0 + int'(((row - at) & 1) * 2 + ((col - al) & 1)), v);
        end else if (rows_on && col >= redge) begin
            add(rfrs_pkg::GRP_RIGHT, v);
        end else if (row >= bedge) begin
            add(rfrs_pkg::GRP_BOTTOM, v);
        end
        if (col + 1 < w) begin
            col++;
            return;
        end
        col = 0;
        if (row + 1 < h) begin
            row++;
            return;
        end
        row = 0;
        frames++;
        queue_due(make(rfrs_pkg::RGN_ACTIVE, gmin[0], gmax[0], gsum[0], gcnt[0], 0));
        queue_due(make(rfrs_pkg::RGN_RIGHT, gmin[1], gmax[1], gsum[1], gcnt[1], 0));
        queue_due(make(rfrs_pkg::RGN_BOTTOM, gmin[2], gmax[2], gsum[2], gcnt[2], 0));
        // combined margins: merge extremes of non-empty groups only
        mn = 16'hFFFF; mx = 0;
        for (int g = rfrs_pkg::GRP_RIGHT; g <= rfrs_pkg::GRP_BOTTOM; g++) begin
            if (gcnt[g] != 0) begin
                if (gmin[g] < mn) mn = gmin[g];
                if (gmax[g] > mx) mx = gmax[g];
            end
        end
        queue_due(make(rfrs_pkg::RGN_INACTIVE, mn, mx, gsum[1] + gsum[2],
                       gcnt[1] + gcnt[2], 0));
        for (int k = 0; k < 4; k++) begin
            queue_due(make(rfrs_pkg::RGN_INACTIVE + 3'(k + 1),
                           gmin[rfrs_pkg::GRP_SITE0 + k], gmax[rfrs_pkg::GRP_SITE0 + k],
                           gsum[rfrs_pkg::GRP_SITE0 + k], gcnt[rfrs_pkg::GRP_SITE0 + k],
                           k == 3));
        end
        clear_groups();
    endfunction

    function void cmp(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
        end
    endfunction

    function void check_result(rfrs_pkg::t_result got);
        rfrs_pkg::t_result want;
        if (due_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual region %0d",
                     $realtime, got.region);
            return;
        end
        want = due_q.pop_front();
        checked++;
        cmp("region", want.region, got.region);
        cmp("minimum", want.mn, got.mn);
        cmp("maximum", want.mx, got.mx);
        cmp("total", want.sum, got.sum);
        cmp("sample_count", want.cnt, got.cnt);
        cmp("mean_q8", want.mean, got.mean);
        cmp("last", want.last, got.last);
    endfunction
endclass

module raw_frame_region_statistics_test;
    import rfrs_pkg::*;

    logic                 i_clk, i_rst_n;
    logic                 i_push, o_full;
    logic [SMP_W-1:0]     i_sample;
    logic                 i_frame_start;
    logic                 o_empty, i_pop;
    logic [RGN_W-1:0]     o_region;
    logic [SMP_W-1:0]     o_minimum, o_maximum;
    logic [SUM_W-1:0]     o_total;
    logic [CNT_W-1:0]     o_sample_count;
    logic [MEAN_W-1:0]    o_mean_q8;
    logic                 o_last;
    logic                 i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    frame_stats_board board;
    bit calm;
    bit hold_pop;
    int samples_sent;

    raw_frame_region_statistics dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3ms;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one sample request and hold it until accepted.
    task automatic send_sample(logic [15:0] v, logic fs);
        if (!calm && $urandom_range(0, 9) == 0) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_sample <= v;
        i_frame_start <= fs;
        do @(posedge i_clk); while (o_full);
        board.note_sample(v, fs);
        samples_sent++;
    endtask

    task automatic send_frame();
        int n;
        n = board.frames;
        while (board.frames == n) send_sample(pick_sample(), $urandom_range(0, 40) == 0);
    endtask

    // Drain all pending results, then let in-flight work settle.
    task automatic drain();
        i_push <= 1'b0;
        while (board.due_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [10:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, d);
    endtask

    task automatic setup(int fw, int fh, int al, int at, int aw, int ah);
        drain();
        write_reg(CFG_FRAME_WIDTH, 11'(fw));
        write_reg(CFG_FRAME_HEIGHT, 11'(fh));
        write_reg(CFG_AREA_LEFT, 11'(al));
        write_reg(CFG_AREA_TOP, 11'(at));
        write_reg(CFG_AREA_WIDTH, 11'(aw));
        write_reg(CFG_AREA_HEIGHT, 11'(ah));
        i_cfg_valid <= 1'b0;
    endtask

    // Pop results at random; hold off while the pressure window is open.
    task automatic take_results();
        t_result got;
        forever begin
            if (hold_pop || (!calm && $urandom_range(0, 7) == 0)) begin
                i_pop <= 1'b0;
                if (hold_pop) @(posedge i_clk);
                else repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                i_pop <= 1'b1;
                @(posedge i_clk);
                if (!o_empty) begin
                    got.region = o_region; got.mn = o_minimum; got.mx = o_maximum;
                    got.sum = o_total; got.cnt = o_sample_count; got.mean = o_mean_q8;
                    got.last = o_last;
                    board.check_result(got);
                end
            end
        end
    endtask

    initial begin
        int rand_samples;
        board = new();
        calm = 0; hold_pop = 0; samples_sent = 0;
        i_rst_n <= 1'b0; i_push <= 1'b0; i_sample <= '0; i_frame_start <= 1'b0;
        i_pop <= 1'b0; i_cfg_valid <= 1'b0; i_cfg_index <= CFG_FRAME_WIDTH; i_cfg_data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        fork take_results(); join_none

        // zero frame size acts as a single sample per frame
        setup(0, 0, 0, 0, 1, 1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h8001, 1'b0);

        // area inside a small frame with right and bottom margins
        setup(5, 4, 1, 1, 2, 2);
        send_frame();
        send_sample(16'h1234, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_frame();
        // leave a partial row so the next size change starts past the new end
        repeat (3) send_sample(pick_sample(), 1'b0);
        setup(2, 2, 0, 0, 1, 1);
        send_frame();

        rand_samples = 0;
        for (int ph = 0; rand_samples < 130; ph++) begin
            int sent_mark;
            setup($urandom_range(0, 8), $urandom_range(0, 6), $urandom_range(0, 4),
                  $urandom_range(0, 4), $urandom_range(0, 6), $urandom_range(0, 6));
            if (ph == 0) begin
                hold_pop = 1;
                fork begin
                    repeat (1500) @(posedge i_clk);
                    hold_pop = 0;
                end join_none
            end
            if (rand_samples > 100) calm = 1;
            sent_mark = samples_sent;
            repeat ((ph == 0) ? 4 : $urandom_range(2, 4)) send_frame();
            rand_samples += samples_sent - sent_mark;
        end

        drain();
        repeat (400) @(posedge i_clk);
        $display("tb: %0d samples sent, %0d frames, %0d region results checked",
                 samples_sent, board.frames, board.checked);
        $display("tb: covered clamped sizes, margins, parity sites, restarts and backpressure");
        if (board.errors == 0 && board.due_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// File: raw_frame_region_statistics.f
design/rfrs_pkg.sv
design/rfrs_front.sv
design/rfrs_snap_q.sv
design/rfrs_back.sv
design/raw_frame_region_statistics.sv
design/rfrs_checker.sv
bench/raw_frame_region_statistics_test.sv
